FILE: rtl/square_matrix_multiply_defines.svh
// assertion macros used by the square matrix multiplier checker
`ifndef SQUARE_MATRIX_MULTIPLY_DEFINES_SVH
`define SQUARE_MATRIX_MULTIPLY_DEFINES_SVH

// same-cycle implication, reset disables the check
`define SMM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("square matrix multiply check failed");

// next-cycle implication, reset disables the check
`define SMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("square matrix multiply check failed");

`endif

FILE: rtl/smm_pkg.sv
// shared constants and types of the square matrix multiplier
`timescale 1ns / 1ps

package smm_pkg;

	localparam int DEF_MAX_DIM    = 8;
	localparam int DEF_ELEM_WIDTH = 16;

	// row and column indexes on the result channel
	localparam int IDX_W = 3;
	// matrix size register
	localparam int CFG_W = 4;
	localparam logic [CFG_W-1:0] MATRIX_SIZE_RESET = 4'd8;

	// per-cell control from the sequencer
	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_row;
		logic             clr;
		logic             shift;
	} cell_ctl_t;

endpackage

FILE: rtl/smm_ifs.sv
// valid/ready channel interfaces for element pairs and product results
`timescale 1ns / 1ps

interface smm_load_if import smm_pkg::*; #(
	parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
);
	logic                         valid;
	logic                         ready;
	logic signed [ELEM_WIDTH-1:0] a_elem;
	logic signed [ELEM_WIDTH-1:0] b_elem;

	modport source (output valid, a_elem, b_elem, input ready);
	modport sink (input valid, a_elem, b_elem, output ready);
endinterface

interface smm_result_if import smm_pkg::*; #(
	parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
);
	logic                             valid;
	logic                             ready;
	logic signed [2*ELEM_WIDTH+2:0]   prod_elem;
	logic        [IDX_W-1:0]          out_row;
	logic        [IDX_W-1:0]          out_col;
	logic                             is_last;

	modport source (output valid, prod_elem, out_row, out_col, is_last, input ready);
	modport sink (input valid, prod_elem, out_row, out_col, is_last, output ready);
endinterface

FILE: rtl/square_matrix_multiply.sv
// Square matrix multiplier, n x n with n from matrix_size (0 reads as 1, above MAX_DIM as
// MAX_DIM). Element pairs of A and B load at one beat per cycle in row-major order; A goes
// to a RAM, each column of B to one cell of a chain of MAX_DIM multiply-accumulate cells.
// After the n*n-th beat the block stops taking input and works one output row at a time:
// A[i][k] for k from 0 to n-1 streams down the chain, ST_WAIT lets the chain settle, then
// the n results of the row shift out of the chain one beat per cycle when the result side
// is ready. A run's speed is bound by the single A read port and the one output beat per cycle.
// Writing matrix_size restarts loading; write it only while no run is in progress.
`timescale 1ns / 1ps

module square_matrix_multiply import smm_pkg::*; #(
	parameter int MAX_DIM    = DEF_MAX_DIM,
	parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	smm_load_if.sink         load,
	smm_result_if.source     result
);

	localparam int ACC_W  = 2*ELEM_WIDTH + 3;
	localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1;
	localparam int WAIT_W = $clog2(MAX_DIM + 2);

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	state_t             state_q;
	logic [CFG_W-1:0]   size_q;
	logic [CFG_W-1:0]   dim;
	logic [IDX_W-1:0]   nm1;
	logic [IDX_W-1:0]   ld_row_q, ld_col_q;
	logic [ADDR_W-1:0]  ld_pos_q;
	logic [IDX_W-1:0]   row_q, col_q, k_q;
	logic [ADDR_W-1:0]  row_base_q;
	logic [WAIT_W-1:0]  wait_q;
	logic               load_go, load_done, drain_go, row_done, run_done;
	logic               clr_cells;

	logic signed [ELEM_WIDTH-1:0] ram_rdata;
	logic        [IDX_W-1:0]      issue_k_s1;
	logic                         issue_v_s1;

	logic signed [ELEM_WIDTH-1:0] a_c   [MAX_DIM+1];
	logic        [IDX_W-1:0]      k_c   [MAX_DIM+1];
	logic                         v_c   [MAX_DIM+1];
	logic signed [ACC_W-1:0]      acc_c [MAX_DIM+1];

	logic                    res_v_q;
	logic signed [ACC_W-1:0] res_prod_q;
	logic [IDX_W-1:0]        res_row_q, res_col_q;
	logic                    res_last_q;

	// size in use
	always_comb begin
		priority if (size_q == '0) begin
			dim = CFG_W'(1);
		end else if (size_q > CFG_W'(MAX_DIM)) begin
			dim = CFG_W'(MAX_DIM);
		end else begin
			dim = size_q;
		end
	end
	assign nm1 = IDX_W'(dim - CFG_W'(1));

	assign load.ready = (state_q == ST_LOAD);
	assign load_go    = load.valid && load.ready;
	assign load_done  = load_go && (ld_row_q == nm1) && (ld_col_q == nm1);
	assign drain_go   = (state_q == ST_DRAIN) && (!res_v_q || result.ready);
	assign row_done   = drain_go && (col_q == nm1);
	assign run_done   = row_done && (row_q == nm1);
	// accumulators restart at the beginning of each row
	assign clr_cells  = load_done || (row_done && !run_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			size_q     <= MATRIX_SIZE_RESET;
			ld_row_q   <= '0;
			ld_col_q   <= '0;
			ld_pos_q   <= '0;
			row_q      <= '0;
			col_q      <= '0;
			k_q        <= '0;
			row_base_q <= '0;
			wait_q     <= '0;
		end else begin
			if (cfg_we) begin
				size_q   <= cfg_wdata;
				ld_row_q <= '0;
				ld_col_q <= '0;
				ld_pos_q <= '0;
			end else if (load_go) begin
				if (load_done) begin
					ld_row_q <= '0;
					ld_col_q <= '0;
					ld_pos_q <= '0;
				end else begin
					ld_pos_q <= ld_pos_q + ADDR_W'(1);
					if (ld_col_q == nm1) begin
						ld_col_q <= '0;
						ld_row_q <= ld_row_q + IDX_W'(1);
					end else begin
						ld_col_q <= ld_col_q + IDX_W'(1);
					end
				end
			end

			unique case (state_q)
				ST_LOAD: begin
					if (load_done) begin
						state_q    <= ST_RUN;
						row_q      <= '0;
						col_q      <= '0;
						k_q        <= '0;
						row_base_q <= '0;
					end
				end
				ST_RUN: begin
					k_q <= k_q + IDX_W'(1);
					if (k_q == nm1) begin
						state_q <= ST_WAIT;
						wait_q  <= '0;
					end
				end
				ST_WAIT: begin
					wait_q <= wait_q + WAIT_W'(1);
					if (wait_q == WAIT_W'(MAX_DIM)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (drain_go) begin
						col_q <= col_q + IDX_W'(1);
						if (row_done) begin
							col_q <= '0;
							if (run_done) begin
								state_q <= ST_LOAD;
							end else begin
								state_q    <= ST_RUN;
								row_q      <= row_q + IDX_W'(1);
								row_base_q <= row_base_q + ADDR_W'(dim);
								k_q        <= '0;
							end
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	smm_ram #(
		.WIDTH(ELEM_WIDTH),
		.DEPTH(MAX_DIM*MAX_DIM)
	) u_a_ram (
		.clk  (clk),
		.we   (load_go),
		.waddr(ld_pos_q),
		.wdata(load.a_elem),
		.raddr(row_base_q + ADDR_W'(k_q)),
		.rdata(ram_rdata)
	);

	// issue tag follows the registered RAM read
	always_ff @(posedge clk) begin
		issue_k_s1 <= k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_v_s1 <= 1'b0;
		end else begin
			issue_v_s1 <= (state_q == ST_RUN);
		end
	end

	assign a_c[0]         = ram_rdata;
	assign k_c[0]         = issue_k_s1;
	assign v_c[0]         = issue_v_s1;
	assign acc_c[MAX_DIM] = '0;

	for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
		cell_ctl_t ctl;

		assign ctl.wr_en  = load_go && (ld_col_q == IDX_W'(j));
		assign ctl.wr_row = ld_row_q;
		assign ctl.clr    = clr_cells;
		assign ctl.shift  = drain_go;

		smm_cell #(
			.MAX_DIM   (MAX_DIM),
			.ELEM_WIDTH(ELEM_WIDTH)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.wr_data(load.b_elem),
			.a_in   (a_c[j]),
			.k_in   (k_c[j]),
			.v_in   (v_c[j]),
			.a_out  (a_c[j+1]),
			.k_out  (k_c[j+1]),
			.v_out  (v_c[j+1]),
			.acc_in (acc_c[j+1]),
			.acc_out(acc_c[j])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (drain_go) begin
			res_v_q <= 1'b1;
		end else if (result.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (drain_go) begin
			res_prod_q <= acc_c[0];
			res_row_q  <= row_q;
			res_col_q  <= col_q;
			res_last_q <= run_done;
		end
	end

	assign result.valid     = res_v_q;
	assign result.prod_elem = res_prod_q;
	assign result.out_row   = res_row_q;
	assign result.out_col   = res_col_q;
	assign result.is_last   = res_last_q;

endmodule

FILE: rtl/smm_ram.sv
// generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module smm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/smm_cell.sv
// one multiply-accumulate cell: holds a column of B and one result of the current row
`timescale 1ns / 1ps

module smm_cell import smm_pkg::*; #(
	parameter int MAX_DIM    = DEF_MAX_DIM,
	parameter int ELEM_WIDTH = DEF_ELEM_WIDTH,
	localparam int ACC_W = 2*ELEM_WIDTH + 3,
	localparam int KW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cell_ctl_t                    ctl,
	input  logic signed [ELEM_WIDTH-1:0] wr_data,
	input  logic signed [ELEM_WIDTH-1:0] a_in,
	input  logic        [IDX_W-1:0]      k_in,
	input  logic                         v_in,
	output logic signed [ELEM_WIDTH-1:0] a_out,
	output logic        [IDX_W-1:0]      k_out,
	output logic                         v_out,
	input  logic signed [ACC_W-1:0]      acc_in,
	output logic signed [ACC_W-1:0]      acc_out
);

	logic signed [ELEM_WIDTH-1:0]   b_col_q [MAX_DIM];
	logic signed [ELEM_WIDTH-1:0]   a_q;
	logic        [IDX_W-1:0]        k_q;
	logic                           v_q;
	logic signed [2*ELEM_WIDTH-1:0] prod_s1;
	logic                           pv_s1;
	logic signed [ACC_W-1:0]        acc_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			b_col_q[ctl.wr_row[KW-1:0]] <= wr_data;
		end
		a_q     <= a_in;
		k_q     <= k_in;
		prod_s1 <= a_in * b_col_q[k_in[KW-1:0]];
		priority if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.shift) begin
			// results move one cell toward the output
			acc_q <= acc_in;
		end else if (pv_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= 1'b0;
			pv_s1 <= 1'b0;
		end else begin
			v_q   <= v_in;
			pv_s1 <= v_in;
		end
	end

	assign a_out   = a_q;
	assign k_out   = k_q;
	assign v_out   = v_q;
	assign acc_out = acc_q;

endmodule

FILE: rtl/smm_checker.sv
// port-level checks of the square matrix multiplier and their binding
`timescale 1ns / 1ps
`include "square_matrix_multiply_defines.svh"

module smm_checker import smm_pkg::*; #(
	parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     load_ready,
	input logic                     res_valid,
	input logic                     res_ready,
	input logic [2*ELEM_WIDTH+2:0]  res_prod,
	input logic [IDX_W-1:0]         res_row,
	input logic [IDX_W-1:0]         res_col,
	input logic                     res_last
);

	// a stalled result beat stays
	`SMM_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	`SMM_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && !res_ready, $stable(res_prod))

	// no new loading while a run still has results to give
	`SMM_ASSERT_IMPLY(a_no_load_mid_run, clk, arst_n, res_valid && !res_last, !load_ready)

	// the final result sits on the diagonal corner
	`SMM_ASSERT_IMPLY(a_last_corner, clk, arst_n, res_valid && res_last, res_row == res_col)

endmodule

bind square_matrix_multiply smm_checker #(
	.ELEM_WIDTH(ELEM_WIDTH)
) u_smm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.load_ready(load.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_prod  (result.prod_elem),
	.res_row   (result.out_row),
	.res_col   (result.out_col),
	.res_last  (result.is_last)
);
